// File: rtl/ccd_command_timing_calc_macros.svh
// Assertion macros used by the port-level checker of the CCD timing calculator.
`ifndef CCD_COMMAND_TIMING_CALC_MACROS_SVH
`define CCD_COMMAND_TIMING_CALC_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CCD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define CCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/ccd_pkg.sv
// Types and constants of the CCD command timing calculator.
package ccd_pkg;

  localparam logic [7:0] CharG = 8'h47;
  localparam logic [7:0] CharS = 8'h53;

  localparam int CfgAddrW = 5;
  localparam int RegIdxW  = 3;

  localparam logic [7:0]  RstTicksPerUs = 8'd80;
  localparam logic [7:0]  RstShPulseUs  = 8'd2;
  localparam logic [7:0]  RstIcgPulseUs = 8'd10;
  localparam logic [15:0] RstShIcgGap   = 16'd40;
  localparam logic [31:0] RstReadout    = 32'd2364160;
  localparam logic [15:0] RstStartDelay = 16'd1500;

  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam int DivSteps = 32;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [RegIdxW-1:0] {
    REG_TICKS_PER_US = 3'd0,
    REG_SH_PULSE_US  = 3'd1,
    REG_ICG_PULSE_US = 3'd2,
    REG_SH_ICG_GAP   = 3'd3,
    REG_READOUT      = 3'd4,
    REG_START_DELAY  = 3'd5
  } ccd_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_FIN
  } ccd_state_e;

  typedef struct packed {
    logic [7:0]  ticks_per_us;
    logic [7:0]  sh_pulse_us;
    logic [7:0]  icg_pulse_us;
    logic [15:0] sh_icg_gap;
    logic [31:0] readout_ticks;
    logic [15:0] start_delay;
  } ccd_cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] time_val;
  } ccd_item_t;

  typedef struct packed {
    logic        start_res;
    logic        range_error;
    logic [31:0] sh_period;
    logic [15:0] sh_high;
    logic [32:0] icg_period;
    logic [15:0] icg_high;
    logic [15:0] icg_to_sh_offset;
    logic [32:0] start_preload;
  } ccd_res_t;

endpackage

// File: rtl/ccd_front.sv
// Byte parser: finds the GS prefix and gathers the time bytes.
module ccd_front import ccd_pkg::*; #(
  parameter int TIME_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output ccd_item_t  item_o
);

  logic [7:0]  prev_q, prev_d;
  logic [2:0]  left_q, left_d;
  logic [31:0] time_q, time_d;

  always_comb begin
    prev_d      = byte_i;
    left_d      = left_q;
    time_d      = time_q;
    item_o.cmd  = 1'b0;
    if (left_q != 3'd0) begin
      time_d     = {time_q[23:0], byte_i};
      left_d     = left_q - 3'd1;
      item_o.cmd = (left_q == 3'd1);
    end else if (prev_q == CharG && byte_i == CharS) begin
      left_d = 3'(TIME_BYTES);
      time_d = '0;
    end
    item_o.time_val = time_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      left_q <= '0;
      time_q <= '0;
    end else if (accept_i) begin
      prev_q <= prev_d;
      left_q <= left_d;
      time_q <= time_d;
    end
  end

endmodule

// File: rtl/ccd_fifo.sv
// Short queue between the parser and the timing engine.
module ccd_fifo import ccd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  ccd_item_t wdata_i,
  output logic      full_o,
  input  logic      rd_i,
  output ccd_item_t rdata_o,
  output logic      empty_o
);

  ccd_item_t              mem_q [QDepth];
  logic [QPtrW-1:0]       wp_q, rp_q;
  logic [QCntW-1:0]       cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + QPtrW'(1);
      if (rd_i) rp_q <= rp_q + QPtrW'(1);
      if (wr_i && !rd_i) cnt_q <= cnt_q + QCntW'(1);
      else if (rd_i && !wr_i) cnt_q <= cnt_q - QCntW'(1);
    end
  end

endmodule

// File: rtl/ccd_div.sv
// Restoring divider, one quotient bit per cycle, remainder only.
module ccd_div import ccd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [31:0]        dvd_q, dvs_q, rem_q;
  logic [32:0]        trial;
  logic [32:0]        diff;
  logic [31:0]        rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[31]};
    diff  = trial - {1'b0, dvs_q};
    rem_d = (trial >= {1'b0, dvs_q}) ? diff[31:0] : trial[31:0];
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      rem_q <= rem_d;
    end
  end

endmodule

// File: rtl/ccd_back.sv
// Timing engine: periods, pulse widths, offset and preload per command.
module ccd_back import ccd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ccd_cfg_t  cfg_i,
  input  ccd_item_t item_i,
  input  logic      item_empty_i,
  output logic      item_pop_o,
  output ccd_res_t  res_o,
  output logic      res_empty_o,
  input  logic      res_pop_i
);

  ccd_state_e  state_q, state_d;
  logic [31:0] time_q, time_d;
  logic [39:0] sh_q, sh_d;
  logic [15:0] shh_q, shh_d;
  logic [15:0] icgh_q, icgh_d;
  logic [33:0] icg_q, icg_d;
  logic [16:0] sub_q, sub_d;
  ccd_res_t    res_q, res_d;
  logic        vld_q, vld_d;
  logic        div_start, div_done;
  logic [31:0] div_rem;
  logic [33:0] pre_sum, pre_sub, pre_val;
  logic [16:0] off_val;

  ccd_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(cfg_i.readout_ticks),
    .divisor_i (sh_q[31:0]),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d    = state_q;
    time_d     = time_q;
    sh_d       = sh_q;
    shh_d      = shh_q;
    icgh_d     = icgh_q;
    icg_d      = icg_q;
    sub_d      = sub_q;
    res_d      = res_q;
    vld_d      = vld_q && !res_pop_i;
    item_pop_o = 1'b0;
    div_start  = 1'b0;
    pre_sum    = 34'(icg_q) + 34'(cfg_i.start_delay);
    pre_sub    = 34'(sub_q) + 34'd1;
    pre_val    = (pre_sum > pre_sub) ? pre_sum - pre_sub : '0;
    off_val    = ({1'b0, icgh_q} > sub_q) ? {1'b0, icgh_q} - sub_q : '0;
    case (state_q)
      ST_IDLE: begin
        if (!item_empty_i && (!vld_q || res_pop_i)) begin
          item_pop_o = 1'b1;
          if (item_i.cmd) begin
            time_d  = item_i.time_val;
            state_d = ST_MUL;
          end else begin
            res_d = '0;
            vld_d = 1'b1;
          end
        end
      end
      ST_MUL: begin
        sh_d    = 40'(time_q) * 40'(cfg_i.ticks_per_us);
        shh_d   = 16'(cfg_i.sh_pulse_us) * 16'(cfg_i.ticks_per_us);
        icgh_d  = 16'(cfg_i.icg_pulse_us) * 16'(cfg_i.ticks_per_us);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (sh_q[39:32] != '0 || sh_q[31:0] == '0) begin
          res_d             = '0;
          res_d.range_error = 1'b1;
          vld_d             = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          icg_d   = 34'(cfg_i.readout_ticks) - 34'(div_rem) + 34'(sh_q[31:0]);
          sub_d   = 17'(shh_q) + 17'(cfg_i.sh_icg_gap);
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        res_d.start_res        = 1'b1;
        res_d.range_error      = 1'b0;
        res_d.sh_period        = sh_q[31:0];
        res_d.sh_high          = shh_q;
        res_d.icg_period       = icg_q[32:0];
        res_d.icg_high         = icgh_q;
        res_d.icg_to_sh_offset = off_val[15:0];
        res_d.start_preload    = pre_val[33] ? '1 : pre_val[32:0];
        vld_d                  = 1'b1;
        state_d                = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o       = res_q;
  assign res_empty_o = !vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    sh_q   <= sh_d;
    shh_q  <= shh_d;
    icgh_q <= icgh_d;
    icg_q  <= icg_d;
    sub_q  <= sub_d;
    res_q  <= res_d;
  end

endmodule

// File: rtl/ccd_command_timing_calc.sv
// Top level of the CCD command decoder and timing calculator.
// Every host byte pushed in yields one result. Ordinary bytes pass through
// and give an all-zero result; the fourth time byte after a "GS" prefix
// starts a timing calculation that holds the timing engine while the
// remainder divider sets the ICG period to the smallest multiple of the SH
// period above the readout time. A two-entry queue lets the parser keep
// taking bytes while a calculation runs or a result waits. Registers sit at
// byte offsets 4*i.
module ccd_command_timing_calc import ccd_pkg::*; #(
  parameter int TIME_BYTES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          rx_byte_i,
  output logic                empty,
  input  logic                pop,
  output logic                start_res_o,
  output logic                range_error_o,
  output logic [31:0]         sh_period_o,
  output logic [15:0]         sh_high_o,
  output logic [32:0]         icg_period_o,
  output logic [15:0]         icg_high_o,
  output logic [15:0]         icg_to_sh_offset_o,
  output logic [32:0]         start_preload_o
);

  ccd_cfg_t            cfg_q;
  logic [RegIdxW-1:0]  reg_idx;
  logic                cfg_wr;
  logic                in_acc;
  ccd_item_t           fe_item, q_item;
  logic                q_full, q_empty, q_pop;
  ccd_res_t            res;
  logic                res_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us  <= RstTicksPerUs;
      cfg_q.sh_pulse_us   <= RstShPulseUs;
      cfg_q.icg_pulse_us  <= RstIcgPulseUs;
      cfg_q.sh_icg_gap    <= RstShIcgGap;
      cfg_q.readout_ticks <= RstReadout;
      cfg_q.start_delay   <= RstStartDelay;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TICKS_PER_US: cfg_q.ticks_per_us  <= pwdata[7:0];
        REG_SH_PULSE_US:  cfg_q.sh_pulse_us   <= pwdata[7:0];
        REG_ICG_PULSE_US: cfg_q.icg_pulse_us  <= pwdata[7:0];
        REG_SH_ICG_GAP:   cfg_q.sh_icg_gap    <= pwdata[15:0];
        REG_READOUT:      cfg_q.readout_ticks <= pwdata;
        REG_START_DELAY:  cfg_q.start_delay   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TICKS_PER_US: prdata = 32'(cfg_q.ticks_per_us);
      REG_SH_PULSE_US:  prdata = 32'(cfg_q.sh_pulse_us);
      REG_ICG_PULSE_US: prdata = 32'(cfg_q.icg_pulse_us);
      REG_SH_ICG_GAP:   prdata = 32'(cfg_q.sh_icg_gap);
      REG_READOUT:      prdata = cfg_q.readout_ticks;
      REG_START_DELAY:  prdata = 32'(cfg_q.start_delay);
      default:          prdata = '0;
    endcase
  end

  assign full   = q_full;
  assign in_acc = push && !q_full;

  ccd_front #(.TIME_BYTES(TIME_BYTES)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_acc),
    .byte_i  (rx_byte_i),
    .item_o  (fe_item)
  );

  ccd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (in_acc),
    .wdata_i(fe_item),
    .full_o (q_full),
    .rd_i   (q_pop),
    .rdata_o(q_item),
    .empty_o(q_empty)
  );

  ccd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (q_item),
    .item_empty_i(q_empty),
    .item_pop_o  (q_pop),
    .res_o       (res),
    .res_empty_o (res_empty),
    .res_pop_i   (pop && !res_empty)
  );

  assign empty              = res_empty;
  assign start_res_o        = res.start_res;
  assign range_error_o      = res.range_error;
  assign sh_period_o        = res.sh_period;
  assign sh_high_o          = res.sh_high;
  assign icg_period_o       = res.icg_period;
  assign icg_high_o         = res.icg_high;
  assign icg_to_sh_offset_o = res.icg_to_sh_offset;
  assign start_preload_o    = res.start_preload;

endmodule

// File: rtl/ccd_chk.sv
// Port-level checker for the CCD timing calculator, bound to the top level.
`include "ccd_command_timing_calc_macros.svh"

module ccd_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        start_res_o,
  input logic        range_error_o,
  input logic [31:0] sh_period_o,
  input logic [32:0] icg_period_o,
  input logic [32:0] start_preload_o
);

  logic        res_wait;
  logic        timing_zero;
  logic        icg_ok;
  logic [33:0] res_view;

  assign res_wait    = !empty && !pop;
  assign timing_zero = sh_period_o == '0 && icg_period_o == '0 && start_preload_o == '0;
  assign icg_ok      = sh_period_o != '0 && icg_period_o >= 33'(sh_period_o);
  assign res_view    = {start_res_o, icg_period_o};

  `CCD_ASSERT(a_start_xor_err, clk_i, rst_ni, empty || !(start_res_o && range_error_o))
  `CCD_ASSERT(a_idle_zero, clk_i, rst_ni, empty || start_res_o || timing_zero)
  `CCD_ASSERT(a_icg_ge_sh, clk_i, rst_ni, empty || !start_res_o || icg_ok)
  `CCD_ASSERT_NEXT(a_hold, clk_i, rst_ni, res_wait, !empty && $stable(res_view))

endmodule

bind ccd_command_timing_calc ccd_chk u_chk (.*);

// File: tb/sv/ccd_timing_checker.sv
// Checker for the CCD command timing calculator: predicts every result and compares it.
module ccd_timing_checker import ccd_pkg::*; #(
  parameter int TIME_BYTES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  input  logic                push,
  input  logic                full,
  input  logic [7:0]          rx_byte_i,
  input  logic                empty,
  input  logic                pop,
  input  ccd_res_t            res_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  starts_o,
  output int                  errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPrinted = 25;

  ccd_cfg_t    cfg;
  logic [7:0]  prev_byte_q;
  logic [2:0]  left_q;
  logic [31:0] time_q;
  ccd_res_t    timing_q[$];

  function automatic ccd_res_t timing_for(input logic [31:0] t, input ccd_cfg_t c);
    ccd_res_t    r;
    logic [63:0] tpu, sh, icg, shh, icgh, sub, pre;
    r   = '0;
    tpu = 64'(c.ticks_per_us);
    sh  = 64'(t) * tpu;
    if (t == '0 || sh == '0 || sh > 64'hFFFF_FFFF) begin
      r.range_error = 1'b1;
      return r;
    end
    if (64'(c.readout_ticks) < sh) begin
      icg = sh;
    end else begin
      icg = (64'(c.readout_ticks) / sh + 64'd1) * sh;
    end
    shh  = 64'(c.sh_pulse_us) * tpu;
    icgh = 64'(c.icg_pulse_us) * tpu;
    sub  = shh + 64'(c.sh_icg_gap);
    r.icg_to_sh_offset = (icgh > sub) ? 16'(icgh - sub) : 16'd0;
    sub = sub + 64'd1;
    pre = icg + 64'(c.start_delay);
    pre = (pre > sub) ? pre - sub : 64'd0;
    if (pre > 64'h1_FFFF_FFFF) pre = 64'h1_FFFF_FFFF;
    r.start_res     = 1'b1;
    r.sh_period     = 32'(sh);
    r.sh_high       = 16'(shh);
    r.icg_period    = 33'(icg);
    r.icg_high      = 16'(icgh);
    r.start_preload = 33'(pre);
    return r;
  endfunction

  // Command parser; every byte yields one result, all zero except on the last time byte.
  function automatic ccd_res_t parse_byte(input logic [7:0] b);
    ccd_res_t r;
    r = '0;
    if (left_q != '0) begin
      time_q = {time_q[23:0], b};
      left_q = left_q - 3'd1;
      if (left_q == '0) r = timing_for(time_q, cfg);
    end else if (prev_byte_q == CharG && b == CharS) begin
      left_q = 3'(TIME_BYTES);
      time_q = '0;
    end
    prev_byte_q = b;
    return r;
  endfunction

  task automatic report(input string msg);
    fail_count_o++;
    if (fail_count_o <= MaxPrinted) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [32:0] got,
                             input logic [32:0] want);
    if (got !== want) begin
      report($sformatf("result %0d %s got 0x%0h want 0x%0h", checked_o, name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ccd_res_t want;
    if (!rst_ni) begin
      cfg = '{ticks_per_us: RstTicksPerUs, sh_pulse_us: RstShPulseUs,
              icg_pulse_us: RstIcgPulseUs, sh_icg_gap: RstShIcgGap,
              readout_ticks: RstReadout, start_delay: RstStartDelay};
      prev_byte_q  = '0;
      left_q       = '0;
      time_q       = '0;
      timing_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      starts_o     = 0;
      errors_o     = 0;
      pending_o   <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (ccd_reg_e'(paddr[RegIdxW+1:2]))
          REG_TICKS_PER_US: cfg.ticks_per_us  = pwdata[7:0];
          REG_SH_PULSE_US:  cfg.sh_pulse_us   = pwdata[7:0];
          REG_ICG_PULSE_US: cfg.icg_pulse_us  = pwdata[7:0];
          REG_SH_ICG_GAP:   cfg.sh_icg_gap    = pwdata[15:0];
          REG_READOUT:      cfg.readout_ticks = pwdata;
          REG_START_DELAY:  cfg.start_delay   = pwdata[15:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (timing_q.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          want = timing_q.pop_front();
          check_field("start_res", 33'(res_i.start_res), 33'(want.start_res));
          check_field("range_error", 33'(res_i.range_error), 33'(want.range_error));
          check_field("sh_period", 33'(res_i.sh_period), 33'(want.sh_period));
          check_field("sh_high", 33'(res_i.sh_high), 33'(want.sh_high));
          check_field("icg_period", res_i.icg_period, want.icg_period);
          check_field("icg_high", 33'(res_i.icg_high), 33'(want.icg_high));
          check_field("icg_to_sh_offset", 33'(res_i.icg_to_sh_offset),
                      33'(want.icg_to_sh_offset));
          check_field("start_preload", res_i.start_preload, want.start_preload);
          if (want.start_res) starts_o++;
          if (want.range_error) errors_o++;
        end
        checked_o++;
      end
      if (push && !full) timing_q.push_back(parse_byte(rx_byte_i));
      pending_o <= timing_q.size();
    end
  end

endmodule

// File: tb/sv/tb_ccd_command_timing_calc.sv
// Testbench top for the CCD command timing calculator: stimulus, flow control and verdict.
module tb_ccd_command_timing_calc import ccd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TimeBytes  = 4;
  localparam int Limit      = 1_200_000;
  localparam int HoldCycles = 300;
  localparam int Drain      = 40;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                push    = 1'b0;
  logic                full;
  logic [7:0]          rx_byte = '0;
  logic                empty;
  logic                pop     = 1'b0;
  logic                start_res_o, range_error_o;
  logic [31:0]         sh_period_o;
  logic [15:0]         sh_high_o, icg_high_o, icg_to_sh_offset_o;
  logic [32:0]         icg_period_o, start_preload_o;
  ccd_res_t            dut_res;

  int       fail_count, pending, checked, starts, errors;
  int       cycles     = 0;
  int       sent       = 0;
  int       popped     = 0;
  int       stalls     = 0;
  int       settings   = 0;
  int       send_burst = 0;
  int       recv_burst = 0;
  ccd_cfg_t cur_cfg    = '{RstTicksPerUs, RstShPulseUs, RstIcgPulseUs, RstShIcgGap,
                           RstReadout, RstStartDelay};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ccd_command_timing_calc #(.TIME_BYTES(TimeBytes)) i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .rx_byte_i(rx_byte), .empty, .pop,
    .start_res_o, .range_error_o, .sh_period_o, .sh_high_o, .icg_period_o,
    .icg_high_o, .icg_to_sh_offset_o, .start_preload_o
  );

  assign dut_res = '{start_res: start_res_o, range_error: range_error_o,
                     sh_period: sh_period_o, sh_high: sh_high_o, icg_period: icg_period_o,
                     icg_high: icg_high_o, icg_to_sh_offset: icg_to_sh_offset_o,
                     start_preload: start_preload_o};

  ccd_timing_checker #(.TIME_BYTES(TimeBytes)) i_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .push, .full, .rx_byte_i(rx_byte), .empty, .pop, .res_i(dut_res),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .starts_o(starts), .errors_o(errors)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (push && full) stalls <= stalls + 1;
    if (cycles == Limit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, and bursts with none.
  function automatic int gap_len(inout int burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if (r < 3) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [31:0] pick_time();
    int unsigned upper;
    int          r;
    r     = $urandom_range(0, 99);
    upper = (cur_cfg.ticks_per_us == '0) ? 32'hFFFF_FFFF
                                         : 32'hFFFF_FFFF / cur_cfg.ticks_per_us;
    if (r < 8) return '0;
    if (r < 14) return '1;
    if (r < 28) return $urandom;
    if (r < 55) return $urandom_range(1, 2000);
    if (r < 62) return upper + $urandom_range(0, 1);
    return $urandom_range(1, upper);
  endfunction

  function automatic ccd_cfg_t rand_cfg();
    ccd_cfg_t c;
    c.ticks_per_us  = 8'($urandom_range(1, 255));
    c.sh_pulse_us   = 8'($urandom);
    c.icg_pulse_us  = 8'($urandom);
    c.sh_icg_gap    = 16'($urandom);
    c.readout_ticks = $urandom;
    c.start_delay   = 16'($urandom);
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int g;
    g = gap_len(send_burst);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (full);
    sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    send_byte(w[31:24]);
    send_byte(w[23:16]);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  task automatic send_time(input logic [31:0] t);
    send_byte(CharG);
    send_byte(CharS);
    send_word(t);
  endtask

  task automatic send_random(input int count);
    int          done_at, r;
    logic [7:0]  b;
    logic [31:0] t;
    done_at = sent + count;
    while (sent < done_at) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        send_time(pick_time());
      end else if (r < 75) begin
        // last time byte 'G' plus a following 'S' opens the next command
        t = pick_time();
        send_time({t[31:8], CharG});
        send_byte(CharS);
        send_word(pick_time());
      end else if (r < 87) begin
        send_byte(8'($urandom));
      end else if (r < 93) begin
        b = 8'($urandom);
        if (b == CharS) b = CharG;
        send_byte(CharG);
        send_byte(b);
      end else if (r < 96) begin
        send_byte(CharS);
      end else begin
        send_byte(CharG);
        send_byte(CharG);
        send_byte(CharS);
        send_byte(8'($urandom));
      end
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic apply_cfg(input ccd_cfg_t c);
    ccd_reg_e    idx [6];
    logic [31:0] val [6];
    idx = '{REG_TICKS_PER_US, REG_SH_PULSE_US, REG_ICG_PULSE_US, REG_SH_ICG_GAP,
            REG_READOUT, REG_START_DELAY};
    val = '{32'(c.ticks_per_us), 32'(c.sh_pulse_us), 32'(c.icg_pulse_us),
            32'(c.sh_icg_gap), c.readout_ticks, 32'(c.start_delay)};
    for (int i = 0; i < 6; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CfgAddrW'({idx[i], 2'b00});
      pwdata  <= val[i];
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_cfg = c;
    settings++;
  endtask

  initial begin : receiver
    int g;
    int holds;
    holds = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (holds < 2 && popped >= 400 + holds * 900 && push) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds++;
      end else begin
        g = gap_len(recv_burst);
        if (g > 0) begin
          pop <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      popped++;
    end
  end

  initial begin : stimulus
    ccd_cfg_t c;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_time(32'd0);
    send_time(32'hFFFF_FF47);
    send_byte(CharS);
    send_word(32'd1);
    send_random(200);

    settle();
    apply_cfg(ccd_cfg_t'{8'd1, 8'd0, 8'd0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF});
    send_time(32'hFFFF_FFFF);
    send_random(150);

    settle();
    apply_cfg(ccd_cfg_t'{8'd1, 8'd0, 8'd0, 16'd0, 32'd0, 16'd0});
    send_random(150);

    settle();
    apply_cfg(ccd_cfg_t'{8'd255, 8'd255, 8'd255, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF});
    send_random(200);

    // offset and preload both below zero
    settle();
    apply_cfg(ccd_cfg_t'{8'd255, 8'd255, 8'd0, 16'hFFFF, 32'd0, 16'd0});
    send_time(32'd1);
    send_random(150);

    settle();
    c = rand_cfg();
    c.ticks_per_us = '0;
    apply_cfg(c);
    send_random(60);

    for (int n = 0; n < 5; n++) begin
      settle();
      c = rand_cfg();
      if (n == 0) c.readout_ticks = $urandom_range(0, 1000);
      apply_cfg(c);
      send_random(200);
    end

    settle();
    $display("%0d bytes sent over %0d register settings, %0d results checked",
             sent, settings, checked);
    $display("%0d timing results, %0d range errors, %0d cycles with input stalled",
             starts, errors, stalls);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
